// ===== src/aes_pkg.sv =====
// AES-128 shared types, S-box table and round helper functions.
package aes_pkg;

   localparam int unsigned NumRounds = 10;

   typedef logic [127:0] block_type;

   typedef enum logic {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block sits at bits 127-8i .. 120-8i
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      get_byte = b[127 - 8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      t = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
      sub_shift = t;
   endfunction

   function automatic block_type mix(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c + 1);
         a2 = get_byte(s, 4*c + 2);
         a3 = get_byte(s, 4*c + 3);
         t[127 - 32*c -: 8]  = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[119 - 32*c -: 8]  = xtime(a1) ^ xtime(a2) ^ a2 ^ a0 ^ a3;
         t[111 - 32*c -: 8]  = xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1;
         t[103 - 32*c -: 8]  = xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2;
      end
      mix = t;
   endfunction

   // next round key from the previous one
   function automatic block_type next_key(input block_type k, input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      next_key = {w0, w1, w2, w3};
   endfunction

endpackage

// ===== src/aes_round.sv =====
// One pipelined AES round stage: state and round key advance together.
module aes_round
   import aes_pkg::*;
#(
   parameter logic [7:0] Rcon  = 8'h01,
   parameter bit         Final = 1'b0
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_in,
   input  block_type state_in,
   input  block_type key_in,
   output logic      valid_out,
   output block_type state_out,
   output block_type key_out
);

   logic      stage_valid_ff;
   block_type stage_state_ff, stage_state_in;
   block_type stage_key_ff, stage_key_in;
   block_type mixed;

   always_comb begin
      stage_key_in   = next_key(key_in, Rcon);
      mixed          = Final ? sub_shift(state_in) : mix(sub_shift(state_in));
      stage_state_in = mixed ^ stage_key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_state_ff <= stage_state_in;
         stage_key_ff   <= stage_key_in;
      end
   end

   assign valid_out = stage_valid_ff;
   assign state_out = stage_state_ff;
   assign key_out   = stage_key_ff;

endmodule

// ===== src/aes128_block_encrypt_core.sv =====
// Top level: AES-128 encryption pipeline with key registers.
// Pipeline: a whitening register, then ten round stages, each registered.
// Throughput: one item per cycle while the output is not stalled; each round has its own S-box and key step.
// The whole pipe advances together when the output register is empty or taken.
// Reset (synchronous, active high) clears all valid bits and the key to zero.
module aes128_block_encrypt_core
   import aes_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_plain_high,
   input  logic [63:0] req_plain_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   localparam logic [7:0] RCON [NumRounds] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   logic [63:0] key_high_ff, key_low_ff;
   logic        advance;

   logic      v    [NumRounds+1];
   block_type st   [NumRounds+1];
   block_type rk   [NumRounds+1];

   logic      v0_ff;
   block_type st0_ff, rk0_ff;

   // the user must write the key only while idle (the block does not enforce this), so it may feed stage 0 directly
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // global stall: last stage holds the output item
   assign advance   = !v[NumRounds] || rsp_ready;
   assign req_ready = advance;

   // initial AddRoundKey
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st0_ff <= {req_plain_high, req_plain_low} ^ {key_high_ff, key_low_ff};
         rk0_ff <= {key_high_ff, key_low_ff};
      end
   end

   assign v[0]  = v0_ff;
   assign st[0] = st0_ff;
   assign rk[0] = rk0_ff;

   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      aes_round #(
         .Rcon  (RCON[g]),
         .Final (g == NumRounds - 1)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (v[g]),
         .state_in  (st[g]),
         .key_in    (rk[g]),
         .valid_out (v[g+1]),
         .state_out (st[g+1]),
         .key_out   (rk[g+1])
      );
   end

   assign rsp_valid       = v[NumRounds];
   assign rsp_cipher_high = st[NumRounds][127:64];
   assign rsp_cipher_low  = st[NumRounds][63:0];

   // a stalled output item stays valid and its high half holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cipher_high))
      else $error("output item changed under stall");

   // nothing enters while the pipe is stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("accepted while stalled");

   // accepted item reaches first stage
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v[0])
      else $error("item lost at entry");

endmodule

// ===== dv/tb.sv =====
// Testbench for the AES-128 encryption core: random traffic checked against a cipher model.
`timescale 1ns / 100ps

class cipher_scoreboard;
   logic [127:0] pending_blocks[$];
   int unsigned  mismatches;
   int unsigned  checked;

   function new();
      mismatches = 0;
      checked    = 0;
   endfunction

   function void note_plaintext(logic [127:0] expected_cipher);
      pending_blocks.push_back(expected_cipher);
   endfunction

   function void check_cipher(logic [63:0] got_high, logic [63:0] got_low);
      logic [127:0] want;
      if (pending_blocks.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected ciphertext %h_%h", got_high, got_low);
         return;
      end
      want = pending_blocks.pop_front();
      checked++;
      if (want[127:64] !== got_high || want[63:0] !== got_low) begin
         mismatches++;
         if (mismatches <= 10)
            $display("cipher mismatch: expected %h_%h got %h_%h",
                     want[127:64], want[63:0], got_high, got_low);
      end
   endfunction
endclass

module tb;
   import aes_pkg::*;

   localparam int RandomItems = 1800;
   localparam int StallLimit  = 5000;
   localparam int PipeDepth   = 11;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_plain_high = '0;
   logic [63:0] req_plain_low = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [63:0] csr_data = '0;

   aes128_block_encrypt_core u_dut (.*);

   always #1 clock = ~clock;

   cipher_scoreboard board = new();

   // model copy of the key registers
   logic [63:0] model_key_high = '0;
   logic [63:0] model_key_low = '0;
   logic [7:0]  sub_table[256];

   // idling control: 0 = never idle, else idle percentage
   int unsigned send_idle_pct = 14;
   int unsigned recv_idle_pct = 14;
   bit          hold_off = 1'b0;
   int unsigned hold_cycles = 0;
   int unsigned quiet_cycles = 0;
   int unsigned accepted_items = 0;
   int unsigned key_settings = 0;

   // ---------------- cipher model -----------------
   function automatic logic [7:0] gmul2(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i])
            p ^= a;
         a = gmul2(a);
      end
      return p;
   endfunction

   // S-box built from the field inverse and the affine map, not copied
   function automatic void build_sub_table();
      logic [7:0] inv, base, rot;
      int unsigned e;
      for (int v = 0; v < 256; v++) begin
         inv  = 8'h01;
         base = v[7:0];
         e    = 254;
         while (e != 0) begin
            if (e & 1)
               inv = gmul(inv, base);
            base = gmul(base, base);
            e >>= 1;
         end
         if (v == 0)
            inv = '0;
         rot = inv;
         for (int k = 1; k <= 4; k++)
            rot ^= 8'((inv << k) | (inv >> (8 - k)));
         sub_table[v] = rot ^ 8'h63;
      end
   endfunction

   function automatic logic [127:0] encrypt_block(logic [127:0] key, logic [127:0] plain);
      logic [7:0]   st[16], tmp[16], rk[176], t[4], rc, x;
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127-8*i -: 8];
         st[i] = plain[127-8*i -: 8];
      end
      rc = 8'h01;
      for (int c = 16; c < 176; c += 4) begin
         for (int a = 0; a < 4; a++)
            t[a] = rk[c-4+a];
         if (c % 16 == 0) begin
            x    = t[0];
            t[0] = sub_table[t[1]] ^ rc;
            t[1] = sub_table[t[2]];
            t[2] = sub_table[t[3]];
            t[3] = sub_table[x];
            rc   = gmul2(rc);
         end
         for (int a = 0; a < 4; a++)
            rk[c+a] = rk[c-16+a] ^ t[a];
      end
      for (int i = 0; i < 16; i++)
         st[i] ^= rk[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         // sub bytes + column-major row shift
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               tmp[4*c+r] = sub_table[st[4*((c+r)%4)+r]];
         st = tmp;
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               tmp[4*c]   = gmul2(st[4*c]) ^ gmul2(st[4*c+1]) ^ st[4*c+1]
                            ^ st[4*c+2] ^ st[4*c+3];
               tmp[4*c+1] = gmul2(st[4*c+1]) ^ gmul2(st[4*c+2]) ^ st[4*c+2]
                            ^ st[4*c] ^ st[4*c+3];
               tmp[4*c+2] = gmul2(st[4*c+2]) ^ gmul2(st[4*c+3]) ^ st[4*c+3]
                            ^ st[4*c] ^ st[4*c+1];
               tmp[4*c+3] = gmul2(st[4*c+3]) ^ gmul2(st[4*c]) ^ st[4*c]
                            ^ st[4*c+1] ^ st[4*c+2];
            end
            st = tmp;
         end
         for (int i = 0; i < 16; i++)
            st[i] ^= rk[16*rnd+i];
      end
      for (int i = 0; i < 16; i++)
         res[127-8*i -: 8] = st[i];
      return res;
   endfunction

   // ---------------- drivers -----------------
   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // write one key register; only while the core is drained
   task automatic write_key(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_KEY_HIGH)
         model_key_high = value;
      else
         model_key_low = value;
   endtask

   // offer one plaintext item; valid held until taken, dropped only while idling
   task automatic send_block(logic [63:0] plain_high, logic [63:0] plain_low);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_plain_high <= plain_high;
      req_plain_low  <= plain_low;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
   endtask

   // stop offering, then wait for the pipe to empty before touching the key
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending_blocks.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // note each accepted item at the rising edge it is taken
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         board.note_plaintext(encrypt_block({model_key_high, model_key_low},
                                            {req_plain_high, req_plain_low}));
         accepted_items++;
      end
      if (!reset && rsp_valid && rsp_ready)
         board.check_cipher(rsp_cipher_high, rsp_cipher_low);
   end

   // receiver back-pressure; a hold-off stretch blocks it completely
   always @(negedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles--;
         rsp_ready <= 1'b0;
      end else if (hold_off) begin
         hold_off    = 1'b0;
         hold_cycles = 60;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog: too many cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || csr_write || (!req_valid && board.pending_blocks.size() == 0))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("[aes128_block_encrypt_core] ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] keys_hi[4], keys_lo[4];
      build_sub_table();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all-zero key before any write
      send_block('0, '0);
      send_block('1, '1);
      drain();

      // FIPS-197 appendix key, plus extreme plaintexts and single-bit walks
      write_key(CSR_KEY_HIGH, 64'h0001020304050607);
      write_key(CSR_KEY_LOW,  64'h08090a0b0c0d0e0f);
      key_settings++;
      send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block('0, '0);
      send_block('1, '1);
      send_block(64'h8000000000000000, 64'h0000000000000001);
      send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      for (int b = 0; b < 8; b++)
         send_block(64'h1 << (8*b + b), 64'h1 << (63 - 8*b));
      drain();

      // an ignored index does not exist here: csr_index is one bit, both are used
      keys_hi = '{64'hffffffffffffffff, 64'h0, 64'h2b7e151628aed2a6, 64'h0};
      keys_lo = '{64'hffffffffffffffff, 64'hffffffffffffffff, 64'habf7158809cf4f3c, 64'h0};
      for (int k = 0; k < 4; k++) begin
         write_key(CSR_KEY_HIGH, keys_hi[k]);
         write_key(CSR_KEY_LOW,  keys_lo[k]);
         key_settings++;
         send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a);
         send_block(rand64(), rand64());
         drain();
      end

      // random phases, each under a fresh random key
      for (int phase = 0; phase < 6; phase++) begin
         write_key(CSR_KEY_HIGH, rand64());
         write_key(CSR_KEY_LOW,  rand64());
         key_settings++;
         // one phase runs flat out with no idling on either side
         send_idle_pct = (phase == 2) ? 0 : 14;
         recv_idle_pct = (phase == 2) ? 0 : 14;
         for (int i = 0; i < RandomItems / 6; i++) begin
            if (phase == 4 && i == 20)
               hold_off = 1'b1;  // long receiver stall to fill the pipe
            send_block(rand64(), rand64());
         end
         drain();
      end

      repeat (PipeDepth + 5) @(negedge clock);
      $display("covered %0d blocks under %0d key settings, %0d ciphertexts compared",
               accepted_items, key_settings, board.checked);
      $display("flat-out phase and a 60-cycle receiver stall included");
      if (board.mismatches == 0 && board.pending_blocks.size() == 0)
         $display("[aes128_block_encrypt_core] OK");
      else
         $display("[aes128_block_encrypt_core] ERROR");
      $finish;
   end
endmodule
